[rtl/core/rcpc_pkg.sv]
// Package for the RC pulse capture block: field widths, register codes,
// channel roles, reset values and the controller state type.
// No dependencies; compile first.
package rcpc_pkg;

   localparam int CHANNELS_DEF = 6;

   localparam int CH_FW    = 3;
   localparam int TIME_W   = 32;
   localparam int WIDTH_W  = 12;
   localparam int BAND_W   = 10;
   localparam int CMD_W    = 13;
   localparam int QUO_W    = 20;   // |(w - mid) * 180| < 2**20
   localparam int DEN_W    = 12;   // |max - min| <= 4095
   localparam int PROD_W   = 22;
   localparam int APB_AW   = 5;
   localparam int APB_DW   = 32;

   typedef logic [CH_FW-1:0]          channel_type;
   typedef logic [TIME_W-1:0]         time_type;
   typedef logic [WIDTH_W-1:0]        width_type;
   typedef logic [BAND_W-1:0]         band_type;
   typedef logic signed [CMD_W-1:0]   cmd_type;
   typedef logic [QUO_W-1:0]          quo_type;
   typedef logic [DEN_W-1:0]          den_type;

   // Accepted pulse window, exclusive on both ends
   localparam time_type PULSE_LOW  = 32'd900;
   localparam time_type PULSE_HIGH = 32'd2200;

   localparam cmd_type CMD_MIN = -13'sd180;
   localparam cmd_type CMD_MAX = 13'sd4095;
   localparam logic signed [8:0] SCALE_TILT = 9'sd90;
   localparam logic signed [8:0] SCALE_YAW  = 9'sd180;

   // Channel roles
   localparam channel_type CH_THROTTLE = 3'd0;
   localparam channel_type CH_ROLL     = 3'd1;
   localparam channel_type CH_PITCH    = 3'd2;
   localparam channel_type CH_YAW      = 3'd3;
   localparam channel_type CH_AUX1     = 3'd4;
   localparam channel_type CH_AUX2     = 3'd5;

   // Register reset values
   localparam width_type MIN_WIDTH_RST  = 12'd1000;
   localparam width_type MID_WIDTH_RST  = 12'd1500;
   localparam width_type MAX_WIDTH_RST  = 12'd2000;
   localparam band_type  BAND_RST       = 10'd20;
   localparam width_type CUTOFF_RST     = 12'd1100;
   localparam width_type AUX_THR_RST    = 12'd1800;

   typedef enum logic [2:0] {
      REG_MIN_WIDTH    = 3'd0,
      REG_MID_WIDTH    = 3'd1,
      REG_MAX_WIDTH    = 3'd2,
      REG_NEUTRAL_BAND = 3'd3,
      REG_THR_CUTOFF   = 3'd4,
      REG_AUX1_THR     = 3'd5,
      REG_AUX2_THR     = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAPTURE,
      ST_CLAMP,
      ST_SCALE,
      ST_START,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic    start;
      quo_type dividend;
      den_type divisor;
   } div_ctl_type;

   typedef struct packed {
      logic    busy;
      logic    done;
      quo_type quotient;
   } div_stat_type;

   // Stored width after reset: centre for the stick axes, floor elsewhere
   function automatic width_type reset_width(input int idx);
      if (idx >= 1 && idx <= 3) begin
         return MID_WIDTH_RST;
      end
      return MIN_WIDTH_RST;
   endfunction

endpackage

[rtl/core/rcpc_if.sv]
// Handshake channel interfaces for the RC pulse capture block.
// Depends on rcpc_pkg.
interface rcpc_req_if;
   logic                 valid;
   logic                 ready;
   rcpc_pkg::channel_type channel;
   logic                 pin_level;
   rcpc_pkg::time_type   time_us;

   modport source (output valid, channel, pin_level, time_us, input ready);
   modport sink   (input valid, channel, pin_level, time_us, output ready);
endinterface

interface rcpc_rsp_if;
   logic                  valid;
   logic                  ready;
   rcpc_pkg::channel_type out_channel;
   logic                  width_updated;
   rcpc_pkg::width_type   stored_width;
   rcpc_pkg::cmd_type     command;

   modport source (output valid, out_channel, width_updated, stored_width, command,
                   input ready);
   modport sink   (input valid, out_channel, width_updated, stored_width, command,
                   output ready);
endinterface

[rtl/core/rc_pulse_capture_commands.sv]
// Top level of the RC pulse capture block: edge capture, width store,
// clamp and command conversion with a bit-serial divider.
// Depends on rcpc_pkg, rcpc_if.sv (rcpc_req_if, rcpc_rsp_if) and rcpc_div.
//
//   Port group  Dir  Handshake          Transaction
//   req         in   valid/ready        one edge: channel, pin level, time stamp
//   rsp         out  valid/ready        one result: channel, update flag, width, command
//   csr_*       in   APB, pready high   write or read of one 32-bit register at 4*index
//
// After the accepting edge a transaction passes the capture, clamp and scale states to
// the done state, which loads the output register that drives rsp.valid. Roll, pitch and
// yaw outside the neutral band with a nonzero span pass the start and divide states
// between scale and done: the serial divider spends one cycle per quotient bit, 20 bits,
// plus a load step and a finish step.
// One transaction is in flight at a time; req.ready rises again once the result
// sits in the output register, so a stalled rsp.ready holds at most one more.
// Synchronous active-high reset restores the register defaults, zero rise times
// and the default widths; no clearing pass is needed.
module rc_pulse_capture_commands #(
   parameter int CHANNELS = rcpc_pkg::CHANNELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   rcpc_req_if.sink                    req,
   rcpc_rsp_if.source                  rsp,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rcpc_pkg::APB_AW-1:0] csr_paddr,
   input  logic [rcpc_pkg::APB_DW-1:0] csr_pwdata,
   output logic [rcpc_pkg::APB_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import rcpc_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   width_type min_width_ff, mid_width_ff, max_width_ff;
   band_type  band_ff;
   width_type cutoff_ff, aux1_thr_ff, aux2_thr_ff;

   reg_index_type csr_index;
   logic          csr_write;

   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff <= MIN_WIDTH_RST;
         mid_width_ff <= MID_WIDTH_RST;
         max_width_ff <= MAX_WIDTH_RST;
         band_ff      <= BAND_RST;
         cutoff_ff    <= CUTOFF_RST;
         aux1_thr_ff  <= AUX_THR_RST;
         aux2_thr_ff  <= AUX_THR_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MIN_WIDTH:    min_width_ff <= csr_pwdata[WIDTH_W-1:0];
            REG_MID_WIDTH:    mid_width_ff <= csr_pwdata[WIDTH_W-1:0];
            REG_MAX_WIDTH:    max_width_ff <= csr_pwdata[WIDTH_W-1:0];
            REG_NEUTRAL_BAND: band_ff      <= csr_pwdata[BAND_W-1:0];
            REG_THR_CUTOFF:   cutoff_ff    <= csr_pwdata[WIDTH_W-1:0];
            REG_AUX1_THR:     aux1_thr_ff  <= csr_pwdata[WIDTH_W-1:0];
            REG_AUX2_THR:     aux2_thr_ff  <= csr_pwdata[WIDTH_W-1:0];
            default: ;  // writes past the last register are dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MIN_WIDTH:    csr_prdata = APB_DW'(min_width_ff);
         REG_MID_WIDTH:    csr_prdata = APB_DW'(mid_width_ff);
         REG_MAX_WIDTH:    csr_prdata = APB_DW'(max_width_ff);
         REG_NEUTRAL_BAND: csr_prdata = APB_DW'(band_ff);
         REG_THR_CUTOFF:   csr_prdata = APB_DW'(cutoff_ff);
         REG_AUX1_THR:     csr_prdata = APB_DW'(aux1_thr_ff);
         REG_AUX2_THR:     csr_prdata = APB_DW'(aux2_thr_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Controller
   // ---------------------------------------------------------------
   state_type state_ff, state_in;

   logic req_accept;
   logic rsp_load;
   logic angle_go;     // stick axis outside the neutral band with a nonzero span
   div_ctl_type  div_ctl;
   div_stat_type div_stat;

   assign req_accept = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req.ready = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               state_in = ST_CAPTURE;
            end
         end
         ST_CAPTURE: state_in = ST_CLAMP;
         ST_CLAMP:   state_in = ST_SCALE;
         ST_SCALE:   state_in = angle_go ? ST_START : ST_DONE;
         ST_START:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold the finished transaction until the output register frees up
            if (!rsp.valid || rsp.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------
   // Capture: rise times and stored widths per channel
   // ---------------------------------------------------------------
   time_type  rise_ff  [CHANNELS];
   width_type width_ff [CHANNELS];

   logic          ch_ok;
   logic [CH_W-1:0] req_idx;
   channel_type   ch_ff;
   logic [CH_W-1:0] idx_ff;
   logic          ch_ok_ff;
   logic          level_ff;
   time_type      delta_ff;
   logic          pulse_hit;
   logic          updated_ff;
   width_type     cur_width_ff;

   assign ch_ok   = {2'b00, req.channel} < 5'(CHANNELS);
   assign req_idx = CH_W'(req.channel);

   // A falling edge keeps the width only when it lands strictly inside the window
   assign pulse_hit = ch_ok_ff && !level_ff && (delta_ff > PULSE_LOW) &&
                      (delta_ff < PULSE_HIGH);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            rise_ff[i]  <= '0;
            width_ff[i] <= reset_width(i);
         end
      end else begin
         if (req_accept && ch_ok && req.pin_level) begin
            rise_ff[req_idx] <= req.time_us;
         end
         if ((state_ff == ST_CAPTURE) && pulse_hit) begin
            width_ff[idx_ff] <= delta_ff[WIDTH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ch_ff    <= req.channel;
         idx_ff   <= req_idx;
         ch_ok_ff <= ch_ok;
         level_ff <= req.pin_level;
         // Wrap the time stamp difference modulo 2**32
         delta_ff <= req.time_us - rise_ff[req_idx];
      end
      if (state_ff == ST_CAPTURE) begin
         updated_ff <= pulse_hit;
         if (!ch_ok_ff) begin
            cur_width_ff <= '0;
         end else if (pulse_hit) begin
            cur_width_ff <= delta_ff[WIDTH_W-1:0];
         end else begin
            cur_width_ff <= width_ff[idx_ff];
         end
      end
   end

   // ---------------------------------------------------------------
   // Conversion
   // ---------------------------------------------------------------
   width_type clamp_ff;
   width_type clamp_hi;

   // Clamp to the ceiling first, then to the floor
   assign clamp_hi = (cur_width_ff > max_width_ff) ? max_width_ff : cur_width_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLAMP) begin
         clamp_ff <= (clamp_hi < min_width_ff) ? min_width_ff : clamp_hi;
      end
   end

   logic signed [WIDTH_W+1:0] band_hi, band_lo, w_ext;
   logic signed [WIDTH_W:0]   off_s, span_s;
   logic signed [PROD_W-1:0]  prod;
   logic signed [PROD_W-1:0]  prod_abs;
   logic signed [WIDTH_W:0]   span_abs;
   logic                      band_out;
   logic                      is_tilt, is_yaw;

   assign w_ext   = $signed({2'b00, clamp_ff});
   assign band_hi = $signed({2'b00, mid_width_ff}) + $signed({4'b0000, band_ff});
   assign band_lo = $signed({2'b00, mid_width_ff}) - $signed({4'b0000, band_ff});
   assign band_out = (w_ext > band_hi) || (w_ext < band_lo);

   assign off_s  = $signed({1'b0, clamp_ff}) - $signed({1'b0, mid_width_ff});
   assign span_s = $signed({1'b0, max_width_ff}) - $signed({1'b0, min_width_ff});

   assign is_tilt = ch_ok_ff && ((ch_ff == CH_ROLL) || (ch_ff == CH_PITCH));
   assign is_yaw  = ch_ok_ff && (ch_ff == CH_YAW);

   assign prod = PROD_W'(off_s) * PROD_W'(is_yaw ? SCALE_YAW : SCALE_TILT);
   assign prod_abs = prod[PROD_W-1] ? -prod : prod;
   assign span_abs = span_s[WIDTH_W] ? -span_s : span_s;

   assign angle_go = (is_tilt || is_yaw) && band_out && (span_s != '0);

   cmd_type simple_cmd;
   cmd_type cmd_ff;
   logic    neg_ff;
   quo_type num_ff;
   den_type den_ff;

   // Throttle, aux and out-of-role channels need no divide
   always_comb begin
      simple_cmd = '0;
      if (ch_ok_ff) begin
         case (ch_ff)
            CH_THROTTLE: simple_cmd = (clamp_ff < cutoff_ff) ? '0 : $signed({1'b0, clamp_ff});
            CH_AUX1:     simple_cmd = (clamp_ff > aux1_thr_ff) ? 13'sd1 : 13'sd0;
            CH_AUX2:     simple_cmd = (clamp_ff > aux2_thr_ff) ? 13'sd1 : 13'sd0;
            default:     simple_cmd = '0;
         endcase
      end
   end

   // Saturate the signed quotient into the command range
   cmd_type div_cmd;
   always_comb begin
      if (neg_ff) begin
         div_cmd = (div_stat.quotient > QUO_W'(180)) ? CMD_MIN
                 : -$signed(CMD_W'(div_stat.quotient));
      end else begin
         div_cmd = (div_stat.quotient > QUO_W'(4095)) ? CMD_MAX
                 : $signed(CMD_W'(div_stat.quotient));
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SCALE) begin
         cmd_ff <= simple_cmd;
         neg_ff <= prod[PROD_W-1] ^ span_s[WIDTH_W];
         num_ff <= prod_abs[QUO_W-1:0];
         den_ff <= span_abs[DEN_W-1:0];
      end else if ((state_ff == ST_DIVIDE) && div_stat.done) begin
         cmd_ff <= div_cmd;
      end
   end

   assign div_ctl.start    = (state_ff == ST_START);
   assign div_ctl.dividend = num_ff;
   assign div_ctl.divisor  = den_ff;

   rcpc_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .stat  (div_stat)
   );

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp.out_channel   <= ch_ff;
         rsp.width_updated <= updated_ff;
         rsp.stored_width  <= cur_width_ff;
         rsp.command       <= cmd_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req.ready)
      else $error("second transaction accepted while one is in flight");

   update_in_window: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.width_updated |->
         (rsp.stored_width > 12'd900) && (rsp.stored_width < 12'd2200))
      else $error("updated width outside the pulse window");

   aux_is_binary: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && ((rsp.out_channel == CH_AUX1) || (rsp.out_channel == CH_AUX2)) |->
         (rsp.command == 13'sd0) || (rsp.command == 13'sd1))
      else $error("aux command not binary");

   divide_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == ST_DIVIDE))
      else $error("divider running outside the divide state");

endmodule

[rtl/core/rcpc_div.sv]
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on rcpc_pkg.
module rcpc_div (
   input  logic                   clock,
   input  logic                   reset,
   input  rcpc_pkg::div_ctl_type  ctl,
   output rcpc_pkg::div_stat_type stat
);
   import rcpc_pkg::*;

   localparam int CNT_W = $clog2(QUO_W);

   quo_type           quo_ff;
   den_type           rem_ff;
   den_type           den_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              qbit;

   // Shift the next dividend bit into the partial remainder and try the subtract
   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign qbit  = ~diff[DEN_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUO_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         quo_ff <= ctl.dividend;
         rem_ff <= '0;
         den_ff <= ctl.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[QUO_W-2:0], qbit};
         rem_ff <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      end
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

   no_start_while_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff)
      else $error("divider started while busy");

   done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a running division");

   remainder_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !$past(ctl.start) |-> rem_ff < den_ff)
      else $error("partial remainder reached the divisor");

endmodule
